FILE: rtl/fbdd_pkg.sv
// Shared types and constants for the framebuffer descriptor decoder.
package fbdd_pkg;

  // Largest accepted width or height, in pixels or lines
  localparam int unsigned MAX_DIMENSION = 4096;

  // Register offsets inside the controller window
  localparam logic [12:0] OFF_BG        = 13'h1000;
  localparam logic [12:0] OFF_L1_FETCH  = 13'h1104;
  localparam logic [12:0] OFF_L1_BASE   = 13'h110C;
  localparam logic [12:0] OFF_L1_STRIDE = 13'h1110;
  localparam logic [12:0] OFF_L1_LINES  = 13'h1118;
  localparam logic [12:0] OFF_L1_FORMAT = 13'h111C;
  localparam logic [12:0] OFF_L2_FETCH  = 13'h1204;
  localparam logic [12:0] OFF_L2_BASE   = 13'h120C;
  localparam logic [12:0] OFF_L2_STRIDE = 13'h1210;
  localparam logic [12:0] OFF_L2_LINES  = 13'h1218;
  localparam logic [12:0] OFF_L2_FORMAT = 13'h121C;

  // Frame memory windows, low bound inclusive, high bound exclusive
  localparam logic [31:0] RAM0_LO = 32'h2000_0000;
  localparam logic [31:0] RAM0_HI = 32'h2001_0000;
  localparam logic [31:0] RAM1_LO = 32'h2200_0000;
  localparam logic [31:0] RAM1_HI = 32'h2220_0000;
  localparam logic [31:0] RAM2_LO = 32'h6800_0000;
  localparam logic [31:0] RAM2_HI = 32'h6C00_0000;

  // Pixel format codes
  localparam logic [2:0] FMT_ARGB8888 = 3'd0;
  localparam logic [2:0] FMT_RGB888   = 3'd1;
  localparam logic [2:0] FMT_RGB565   = 3'd2;
  localparam logic [2:0] FMT_ARGB1555 = 3'd3;
  localparam logic [2:0] FMT_ARGB4444 = 3'd4;

  // Chosen layer codes
  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_ONE  = 2'd1;
  localparam logic [1:0] LAYER_TWO  = 2'd2;

  typedef struct packed {
    logic [12:0] reg_offset;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        fb_valid;
    logic [1:0]  active_layer;
    logic [31:0] fb_base;
    logic [12:0] fb_width;
    logic [11:0] fb_height;
    logic [15:0] line_stride;
    logic [2:0]  pixel_format;
    logic        output_enabled;
  } out_item_t;

  typedef struct packed {
    logic [31:0] base;
    logic [15:0] stride;
    logic [10:0] lines_minus_one;
    logic [2:0]  format;
    logic        fetch_on;
  } layer_t;

  typedef struct packed {
    layer_t layer1;
    layer_t layer2;
    logic   background_on;
  } shadow_t;

endpackage

FILE: rtl/fbdd_regs.sv
// Shadow register file: decodes bus writes into the layer descriptor fields.
module fbdd_regs import fbdd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  in_item_t wr_item,
  output shadow_t  state_nxt
);

  shadow_t     state_r;
  logic [31:0] data;

  assign data = wr_item.write_data;

  always_comb begin
    state_nxt = state_r;
    if (wr_en) begin
      unique case (wr_item.reg_offset)
        OFF_BG:        state_nxt.background_on          = data[0];
        OFF_L1_FETCH:  state_nxt.layer1.fetch_on        = data[0];
        OFF_L1_BASE:   state_nxt.layer1.base            = data;
        OFF_L1_STRIDE: state_nxt.layer1.stride          = data[31:16];
        OFF_L1_LINES:  state_nxt.layer1.lines_minus_one = data[26:16];
        OFF_L1_FORMAT: state_nxt.layer1.format          = data[30:28];
        OFF_L2_FETCH:  state_nxt.layer2.fetch_on        = data[0];
        OFF_L2_BASE:   state_nxt.layer2.base            = data;
        OFF_L2_STRIDE: state_nxt.layer2.stride          = data[31:16];
        OFF_L2_LINES:  state_nxt.layer2.lines_minus_one = data[26:16];
        OFF_L2_FORMAT: state_nxt.layer2.format          = data[30:28];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/fbdd_select.sv
// Layer validity check and active descriptor selection.
module fbdd_select import fbdd_pkg::*; (
  input  shadow_t   state,
  output out_item_t desc
);

  typedef struct packed {
    logic        ok;
    logic [12:0] width;
    logic [11:0] height;
  } check_t;

  function automatic check_t check_layer(input layer_t l);
    check_t      c;
    logic [15:0] w;
    logic [11:0] h;
    logic        in_ram;
    case (l.format) inside
      FMT_ARGB8888, FMT_RGB888:               w = {2'b00, l.stride[15:2]};
      FMT_RGB565, FMT_ARGB1555, FMT_ARGB4444: w = {1'b0, l.stride[15:1]};
      default:                                w = l.stride;
    endcase
    h = {1'b0, l.lines_minus_one} + 12'd1;
    in_ram = (l.base >= RAM0_LO && l.base < RAM0_HI) ||
             (l.base >= RAM1_LO && l.base < RAM1_HI) ||
             (l.base >= RAM2_LO && l.base < RAM2_HI);
    c.ok = l.fetch_on && in_ram && (w != 16'd0) &&
           ({1'b0, w} <= 17'(MAX_DIMENSION)) &&
           ({5'd0, h} <= 17'(MAX_DIMENSION));
    c.width  = w[12:0];
    c.height = h;
    return c;
  endfunction

  check_t c1;
  check_t c2;

  assign c1 = check_layer(state.layer1);
  assign c2 = check_layer(state.layer2);

  always_comb begin
    desc = '0;
    if (c1.ok) begin
      desc.fb_valid     = 1'b1;
      desc.active_layer = LAYER_ONE;
      desc.fb_base      = state.layer1.base;
      desc.fb_width     = c1.width;
      desc.fb_height    = c1.height;
      desc.line_stride  = state.layer1.stride;
      desc.pixel_format = state.layer1.format;
    end else if (c2.ok) begin
      desc.fb_valid     = 1'b1;
      desc.active_layer = LAYER_TWO;
      desc.fb_base      = state.layer2.base;
      desc.fb_width     = c2.width;
      desc.fb_height    = c2.height;
      desc.line_stride  = state.layer2.stride;
      desc.pixel_format = state.layer2.format;
    end
    desc.output_enabled = state.background_on;
  end

endmodule

FILE: rtl/framebuffer_descriptor_decode.sv
// Top level of the framebuffer descriptor decoder.
//
//   channel | direction | payload    | handshake
//   in_     | input     | in_item_t  | in_valid / in_stall
//   out_    | output    | out_item_t | out_valid / out_stall
//
// A write is accepted into the input register; when the result register has room,
// the shadow update and layer check feed the result register.
// One item per cycle is sustained while the output is not stalled; the shadow registers
// set that figure, since each write must land before the next one is decoded.
// Reset clears the shadow state and both valid flags.
// A stalled result holds; the input register keeps taking items while it is empty,
// or while the result register has room or drains in the same cycle.
module framebuffer_descriptor_decode import fbdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      s1_ready;
  logic      s2_ready;
  logic      advance;
  shadow_t   state_nxt;
  out_item_t desc;

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !in_valid_r || s2_ready;
  assign advance  = in_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  fbdd_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (advance),
    .wr_item   (in_item_r),
    .state_nxt (state_nxt)
  );

  fbdd_select u_select (
    .state (state_nxt),
    .desc  (desc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= desc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/fbdd_checker.sv
// Port-level checks for the framebuffer descriptor decoder, bound to the top level.
module fbdd_checker import fbdd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result valid right after reset");

  // Stalled input item holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_item)))
    else $error("stalled input item changed");

  // No valid layer: all descriptor fields but output_enabled are zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.fb_valid) |->
      (out_item.active_layer == LAYER_NONE && out_item.fb_base == 32'd0 &&
       out_item.fb_width == 13'd0 && out_item.fb_height == 12'd0 &&
       out_item.line_stride == 16'd0 && out_item.pixel_format == 3'd0))
    else $error("invalid descriptor carries nonzero fields");

  // Valid layer: chosen layer named and dimensions sane
  a_valid_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.fb_valid) |->
      ((out_item.active_layer == LAYER_ONE || out_item.active_layer == LAYER_TWO) &&
       out_item.fb_width != 13'd0 && out_item.fb_height != 12'd0 &&
       {4'd0, out_item.fb_width} <= 17'(MAX_DIMENSION) &&
       {5'd0, out_item.fb_height} <= 17'(MAX_DIMENSION)))
    else $error("valid descriptor with bad layer or dimensions");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind framebuffer_descriptor_decode fbdd_checker u_fbdd_checker (.*);
